// ----- rtl/ups6_pkg.sv -----
// ups6_pkg: shared types, constants and a helper function for the x6 upsampler
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package ups6_pkg;

	localparam int SAMPLE_W        = 16;
	localparam int SUB_COUNT       = 6;
	localparam int LAG_VALUES      = 12;
	localparam int POS_SATURATE    = 4;
	localparam int POS_W           = 3;
	localparam int DEF_QUEUE_DEPTH = 4;

	// interpolation weights in thousandths
	localparam logic [9:0] W_ONE = 10'd1000;

	// exact reciprocal for magnitudes below 2**25: floor(n / 1000)
	localparam logic [25:0] DIV1000_MAGIC = 26'd34359739;
	localparam int          DIV1000_SHIFT = 35;
	// exact reciprocal for magnitudes below 2**18: floor(n / 5)
	localparam logic [18:0] DIV5_MAGIC    = 19'd419431;
	localparam int          DIV5_SHIFT    = 21;

	// one interpolated word passed from the front to the back
	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic                smooth;
		logic                run_end;
		logic                frame_last;
	} raw_word_t;

	localparam int RAW_WORD_W = $bits(raw_word_t);

	function automatic logic [9:0] interp_weight(input logic [2:0] k);
		logic [9:0] w;
		unique case (k)
			3'd0:    w = 10'd166;
			3'd1:    w = 10'd332;
			3'd2:    w = 10'd500;
			3'd3:    w = 10'd668;
			3'd4:    w = 10'd834;
			default: w = W_ONE;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/ups6_if.sv -----
// ups6_if: valid/ready channel interfaces for input samples and output words
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface ups6_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_in;
	logic               frame_last;

	modport source(output valid, sample_in, frame_last, input ready);
	modport sink(input valid, sample_in, frame_last, output ready);
endinterface

interface ups6_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_out;
	logic               run_last;
	logic               frame_end;

	modport source(output valid, sample_out, run_last, frame_end, input ready);
	modport sink(input valid, sample_out, run_last, frame_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/ups6_front.sv -----
// ups6_front: accepts samples, tracks frame position, interpolates six words
// per sample through a pipelined divide-by-1000; depends on ups6_pkg, ups6_if
`timescale 1ns / 1ps
`default_nettype none

module ups6_front (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	ups6_in_if.sink                       feed,
	output      logic                     wr_valid,
	input  wire logic                     wr_ready,
	output      ups6_pkg::raw_word_t      wr_word
);
	import ups6_pkg::*;

	// frame tracking
	logic                      first_q;
	logic [POS_W-1:0]          pos_q;
	logic signed [SAMPLE_W-1:0] prior_in_q;

	// issue stage: one interpolation per cycle while the pipeline is not stalled
	logic                      busy_q;
	logic [2:0]                k_q;
	logic signed [SAMPLE_W-1:0] cur_q;
	logic signed [SAMPLE_W-1:0] prev_q;
	logic                      smooth_q;
	logic                      last_q;

	logic                      v_s1, v_s2, v_s3;
	logic signed [26:0]        p_cur_s1, p_prev_s1;
	logic [2:0]                k_s1, k_s2, k_s3;
	logic                      smooth_s1, smooth_s2, smooth_s3;
	logic                      last_s1, last_s2, last_s3;
	logic                      neg_s2, neg_s3;
	logic [24:0]               mag_s2;
	logic [SAMPLE_W-1:0]       quo_s3;

	logic                      adv;
	logic                      accept;
	logic [9:0]                w;
	logic [9:0]                wc;
	logic signed [27:0]        sum;
	logic [27:0]               mag_full;
	logic [50:0]               prod;

	assign adv        = wr_ready || !v_s3;
	assign feed.ready = adv && (!busy_q || k_q == 3'(SUB_COUNT - 1));
	assign accept     = feed.valid && feed.ready;

	assign w        = interp_weight(k_q);
	assign wc       = W_ONE - w;
	assign sum      = 28'(p_cur_s1) + 28'(p_prev_s1);
	assign mag_full = sum[27] ? 28'(-sum) : 28'(sum);
	assign prod     = 51'(mag_s2) * 51'(DIV1000_MAGIC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q    <= 1'b1;
			pos_q      <= '0;
			prior_in_q <= '0;
			busy_q     <= 1'b0;
			k_q        <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
		end else begin
			if (accept) begin
				prior_in_q <= feed.sample_in;
				if (feed.frame_last) begin
					pos_q   <= '0;
					first_q <= 1'b0;
				end else if (pos_q != POS_W'(POS_SATURATE)) begin
					pos_q <= pos_q + 1'b1;
				end
			end
			if (adv) begin
				if (busy_q && k_q != 3'(SUB_COUNT - 1)) begin
					k_q <= k_q + 1'b1;
				end else begin
					busy_q <= accept;
					k_q    <= '0;
				end
				v_s1 <= busy_q;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q    <= feed.sample_in;
			// the very first sample after reset interpolates from itself
			prev_q   <= (first_q && pos_q == '0) ? feed.sample_in : prior_in_q;
			smooth_q <= (pos_q == POS_W'(POS_SATURATE)) && !first_q;
			last_q   <= feed.frame_last;
		end
		if (adv) begin
			p_cur_s1  <= 27'(cur_q) * 27'($signed({1'b0, w}));
			p_prev_s1 <= 27'(prev_q) * 27'($signed({1'b0, wc}));
			k_s1      <= k_q;
			smooth_s1 <= smooth_q;
			last_s1   <= last_q;

			neg_s2    <= sum[27];
			mag_s2    <= mag_full[24:0];
			k_s2      <= k_s1;
			smooth_s2 <= smooth_s1;
			last_s2   <= last_s1;

			neg_s3    <= neg_s2;
			quo_s3    <= prod[DIV1000_SHIFT +: SAMPLE_W];
			k_s3      <= k_s2;
			smooth_s3 <= smooth_s2;
			last_s3   <= last_s2;
		end
	end

	always_comb begin
		wr_valid           = v_s3;
		wr_word.value      = neg_s3 ? SAMPLE_W'(16'd0 - quo_s3) : quo_s3;
		wr_word.smooth     = smooth_s3;
		wr_word.run_end    = (k_s3 == 3'(SUB_COUNT - 1));
		wr_word.frame_last = (k_s3 == 3'(SUB_COUNT - 1)) && last_s3;
	end

endmodule

`default_nettype wire

// ----- rtl/ups6_queue.sv -----
// ups6_queue: small register queue between front and back, show-ahead read
// depends on nothing but its parameters
`timescale 1ns / 1ps
`default_nettype none

module ups6_queue #(
	parameter int DEPTH = 4,
	parameter int WIDTH = 19
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_valid,
	output      logic             wr_ready,
	input  wire logic [WIDTH-1:0] wr_data,
	output      logic             rd_valid,
	input  wire logic             rd_ready,
	output      logic [WIDTH-1:0] rd_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = slot_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ups6_back.sv -----
// ups6_back: twelve-word lag line, five-point smoothing and end-of-frame flush
// into the output register; depends on ups6_pkg, ups6_if
`timescale 1ns / 1ps
`default_nettype none

module ups6_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                rd_valid,
	output      logic                rd_ready,
	input  wire ups6_pkg::raw_word_t rd_word,
	ups6_out_if.source               result
);
	import ups6_pkg::*;

	localparam int CNT_W = $clog2(LAG_VALUES + 1);

	logic [SAMPLE_W-1:0] line_q [LAG_VALUES];
	logic [CNT_W-1:0]    cnt_q;
	logic                flush_q;
	logic [SAMPLE_W-1:0] e1_q, e2_q;

	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_value_q;
	logic                out_run_last_q;
	logic                out_frame_end_q;

	logic                slot_free;
	logic                full;
	logic                take;
	logic                do_flush;
	logic                emit;
	logic [SAMPLE_W-1:0] emit_value;
	logic                emit_run_last;
	logic                emit_frame_end;

	logic signed [18:0]  sum5;
	logic [18:0]         mag5;
	logic [36:0]         prod5;
	logic [SAMPLE_W-1:0] quo5;
	logic [SAMPLE_W-1:0] smoothed;

	assign slot_free = !out_valid_q || result.ready;
	assign full      = (cnt_q == CNT_W'(LAG_VALUES));
	assign rd_ready  = !flush_q && (!full || slot_free);
	assign take      = rd_valid && rd_ready;
	assign do_flush  = flush_q && slot_free;
	assign emit      = do_flush || (take && full);

	// two emitted values plus the three oldest raw values, truncated toward zero
	assign sum5 = 19'($signed(e1_q)) + 19'($signed(e2_q)) + 19'($signed(line_q[0]))
		+ 19'($signed(line_q[1])) + 19'($signed(line_q[2]));
	assign mag5     = sum5[18] ? 19'(-sum5) : 19'(sum5);
	assign prod5    = 37'(mag5[17:0]) * 37'(DIV5_MAGIC);
	assign quo5     = prod5[DIV5_SHIFT +: SAMPLE_W];
	assign smoothed = sum5[18] ? SAMPLE_W'(16'd0 - quo5) : quo5;

	always_comb begin
		emit_value     = line_q[0];
		emit_run_last  = 1'b0;
		emit_frame_end = 1'b0;
		if (flush_q) begin
			emit_run_last  = (cnt_q == CNT_W'(1));
			emit_frame_end = (cnt_q == CNT_W'(1));
		end else begin
			if (rd_word.smooth) begin
				emit_value = smoothed;
			end
			emit_run_last = rd_word.run_end && !rd_word.frame_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			flush_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_flush) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					flush_q <= 1'b0;
				end
			end else if (take) begin
				if (!full) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (rd_word.frame_last) begin
					flush_q <= 1'b1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			for (int i = 0; i < LAG_VALUES - 1; i++) begin
				line_q[i] <= line_q[i + 1];
			end
			line_q[LAG_VALUES - 1] <= rd_word.value;
			e1_q            <= e2_q;
			e2_q            <= emit_value;
			out_value_q     <= emit_value;
			out_run_last_q  <= emit_run_last;
			out_frame_end_q <= emit_frame_end;
		end else if (take) begin
			line_q[cnt_q[CNT_W-1:0] < CNT_W'(LAG_VALUES) ? cnt_q[3:0] : 4'd0]
				<= rd_word.value;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.sample_out = out_value_q;
	assign result.run_last   = out_run_last_q;
	assign result.frame_end  = out_frame_end_q;

endmodule

`default_nettype wire

// ----- rtl/upsample_x6_interp_smooth_top.sv -----
// upsample_x6_interp_smooth_top: x6 linear-interpolation upsampler with smoothing
// depends on ups6_pkg, ups6_if, ups6_front, ups6_queue, ups6_back
//
//   channel   dir   words per item          payload
//   feed      in    1 per sample            sample_in[15:0] signed, frame_last
//   result    out   0..18 per sample        sample_out[15:0] signed, run_last, frame_end
//
// the front issues one interpolation per cycle, when not stalled, into a shared 3-stage
// multiply/reciprocal pipeline and takes a new sample with the last of each six; the
// back emits one word per cycle when result is ready. a sample that ends a frame
// makes the back flush its lagged words, taking none from the queue meanwhile; the
// front keeps taking samples until the queue fills. arst_n clears frame tracking,
// queue and output valid; stalls on result back up through the queue into feed.ready
`timescale 1ns / 1ps
`default_nettype none

module upsample_x6_interp_smooth_top #(
	parameter int QUEUE_DEPTH = ups6_pkg::DEF_QUEUE_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ups6_in_if.sink    feed,
	ups6_out_if.source result
);
	import ups6_pkg::*;

	logic      wr_valid, wr_ready;
	raw_word_t wr_word;
	logic      rd_valid, rd_ready;
	raw_word_t rd_word;

	ups6_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.feed     (feed),
		.wr_valid (wr_valid),
		.wr_ready (wr_ready),
		.wr_word  (wr_word)
	);

	ups6_queue #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (RAW_WORD_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (wr_valid),
		.wr_ready (wr_ready),
		.wr_data  (wr_word),
		.rd_valid (rd_valid),
		.rd_ready (rd_ready),
		.rd_data  (rd_word)
	);

	ups6_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_valid (rd_valid),
		.rd_ready (rd_ready),
		.rd_word  (rd_word),
		.result   (result)
	);

endmodule

`default_nettype wire

// ----- rtl/ups6_checker.sv -----
// ups6_checker: port-level assertions for the upsampler, bound to the top level
// depends on upsample_x6_interp_smooth_top
`timescale 1ns / 1ps
`default_nettype none

module ups6_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] sample_out,
	input wire logic        run_last,
	input wire logic        frame_end
);
	// words delivered since the last run_last
	logic [4:0] run_len_q;
	logic       out_take;

	assign out_take = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_len_q <= '0;
		end else if (out_take) begin
			run_len_q <= run_last ? 5'd0 : run_len_q + 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out)
			&& $stable(run_last) && $stable(frame_end))
		else $error("result word changed while stalled");

	a_frame_end_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> run_last)
		else $error("frame_end without run_last");

	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_take |-> run_len_q < 5'd18)
		else $error("more than 18 words for one sample");

	a_quiet_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("result valid right after reset");

endmodule

bind upsample_x6_interp_smooth_top ups6_checker u_ups6_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.sample_out (result.sample_out),
	.run_last   (result.run_last),
	.frame_end  (result.frame_end)
);

`default_nettype wire

// ----- dv/upsample_x6_interp_smooth_top_tb.sv -----
// upsample_x6_interp_smooth_top_tb: self-checking bench for the x6 upsampler
// checks every output word against a cycle-free predictor of the interpolation and smoothing
// or a typed row's constant; depends on ups6_pkg, ups6_if and the rtl top
`timescale 1ns / 1ps

module upsample_x6_interp_smooth_top_tb;

	localparam int LAG          = ups6_pkg::LAG_VALUES;
	localparam int SUBS         = ups6_pkg::SUB_COUNT;
	localparam int POS_SAT      = ups6_pkg::POS_SATURATE;
	localparam int RANDOM_ITEMS = 354;
	localparam int SETTLE_CYC   = 40;
	localparam int DRAIN_BOUND  = 60000;
	localparam int HOLD_AFTER   = 300;
	localparam int HOLD_CYC     = 400;
	localparam int REPORT_MAX   = 60;
	localparam int N_DIRECTED   = 26;
	localparam int INTERP_W [5] = '{166, 332, 500, 668, 834};

	typedef struct {
		logic signed [15:0] sample;
		logic               run_last;
		logic               frame_end;
	} out_word_t;

	typedef struct {
		int smp;
		bit last;
		bit typed;
		int count;
		int val;
	} stim_row_t;

	typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

	logic clk;
	logic arst_n;

	ups6_in_if  feed_if();
	ups6_out_if result_if();

	upsample_x6_interp_smooth_top dut (
		.clk   (clk),
		.arst_n(arst_n),
		.feed  (feed_if),
		.result(result_if)
	);

	// predictor state
	logic signed [15:0] prior_in;
	bit                 first_frame;
	logic signed [15:0] pend_raw [LAG];
	logic signed [15:0] emit_hist [2];
	logic [2:0]         frame_pos;

	out_word_t expected_words [$];
	int        mismatches;
	int        words_seen;
	bit        hold_stall;
	int        burst_left;

	// typed rows carry a constant expectation; others come from the predictor
	stim_row_t directed_rows [N_DIRECTED] = '{
		'{ 32767, 1, 1,  6,  32767},	// first sample after reset: no ramp
		'{-32768, 1, 0,  0,  0},
		'{-32768, 1, 1,  6, -32768},
		'{     0, 1, 0,  0,  0},
		'{     0, 1, 1,  6,  0},
		'{     0, 0, 1,  0,  0},
		'{     0, 0, 1,  0,  0},
		'{     0, 0, 1,  6,  0},
		'{     0, 0, 1,  6,  0},
		'{     0, 0, 1,  6,  0},
		'{     0, 1, 1, 18,  0},
		'{ 12345, 0, 0,  0,  0},	// two-sample frame
		'{-12345, 1, 0,  0,  0},
		'{   100, 0, 0,  0,  0},	// three-sample frame
		'{  -200, 0, 0,  0,  0},
		'{   300, 1, 0,  0,  0},
		'{ 32767, 0, 0,  0,  0},	// full-swing frame, smoothed body
		'{-32768, 0, 0,  0,  0},
		'{ 32767, 0, 0,  0,  0},
		'{-32768, 0, 0,  0,  0},
		'{ 32767, 0, 0,  0,  0},
		'{-32768, 0, 0,  0,  0},
		'{    -1, 0, 0,  0,  0},
		'{     1, 0, 0,  0,  0},
		'{-32768, 0, 0,  0,  0},
		'{ 32767, 1, 0,  0,  0}
	};

	function automatic void emit_word(input int v, input bit keep);
		out_word_t w;
		emit_hist[0] = emit_hist[1];
		emit_hist[1] = 16'(v);
		if (keep) begin
			w.sample    = 16'(v);
			w.run_last  = 1'b0;
			w.frame_end = 1'b0;
			expected_words.push_back(w);
		end
	endfunction

	function automatic void upsample_step(input logic signed [15:0] cur, input logic last,
			input bit keep);
		int raw [LAG + SUBS];
		int prev;
		int n;
		int start;
		int first_new;
		int v;
		bit smooth;
		prev      = (first_frame && frame_pos == 0) ? cur : prior_in;
		n         = (frame_pos >= 2) ? LAG : frame_pos * SUBS;
		first_new = expected_words.size();
		start     = 0;
		for (int k = 0; k < n; k++)
			raw[k] = pend_raw[k];
		for (int k = 0; k < 5; k++)
			raw[n + k] = (INTERP_W[k] * cur + (1000 - INTERP_W[k]) * prev) / 1000;
		raw[n + 5] = cur;
		n += SUBS;
		prior_in = cur;
		if (frame_pos >= 2) begin
			smooth = (frame_pos >= POS_SAT) && !first_frame;
			for (int k = 0; k < SUBS; k++) begin
				v = raw[k];
				if (smooth)
					v = (emit_hist[0] + emit_hist[1] + raw[k] + raw[k + 1] + raw[k + 2]) / 5;
				emit_word(v, keep);
			end
			start = SUBS;
		end
		if (last) begin
			for (int k = start; k < n; k++)
				emit_word(raw[k], keep);
			first_frame = 1'b0;
			frame_pos   = '0;
		end else begin
			for (int k = 0; k < n - start; k++)
				pend_raw[k] = 16'(raw[start + k]);
			if (frame_pos < POS_SAT)
				frame_pos = frame_pos + 3'd1;
		end
		if (keep && expected_words.size() > first_new) begin
			expected_words[expected_words.size() - 1].run_last  = 1'b1;
			expected_words[expected_words.size() - 1].frame_end = last;
		end
	endfunction

	task automatic send_sample(input logic signed [15:0] smp, input logic last, input bit typed,
			input int tcount, input int tval);
		int        gap;
		out_word_t w;
		gap = 0;
		if (!hold_stall) begin
			if (burst_left == 0) begin
				gap        = $urandom_range(1, 12);
				burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
			end
			burst_left--;
		end
		if (gap > 0) begin
			@(negedge clk);
			feed_if.valid      <= 1'b0;
			feed_if.sample_in  <= 16'($urandom);
			feed_if.frame_last <= 1'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		feed_if.valid      <= 1'b1;
		feed_if.sample_in  <= smp;
		feed_if.frame_last <= last;
		do @(posedge clk); while (!feed_if.ready);
		upsample_step(smp, last, !typed);
		for (int i = 0; i < tcount; i++) begin
			w.sample    = 16'(tval);
			w.run_last  = (i == tcount - 1);
			w.frame_end = last && (i == tcount - 1);
			expected_words.push_back(w);
		end
	endtask

	// stop offering, let every expected word out, then cover the pipeline tail
	task automatic wait_idle();
		int cnt;
		cnt = 0;
		@(negedge clk);
		feed_if.valid <= 1'b0;
		while (expected_words.size() != 0 && cnt < DRAIN_BOUND) begin
			@(posedge clk);
			cnt++;
		end
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("Mismatches found");
		$finish;
	end

	// receiver pacing, with one long hold-off to back the block up into feed
	initial begin : rx_pace
		rx_mode_t mode;
		int       left;
		int       phase;
		int       hold_count;
		bit       hold_done;
		result_if.ready = 1'b0;
		mode       = RX_FREE;
		left       = 0;
		phase      = 0;
		hold_count = 0;
		hold_done  = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && words_seen >= HOLD_AFTER) begin
				hold_done  = 1'b1;
				hold_stall = 1'b1;
				hold_count = HOLD_CYC;
			end
			if (hold_count > 0) begin
				result_if.ready <= 1'b0;
				hold_count--;
				if (hold_count == 0)
					hold_stall = 1'b0;
			end else begin
				if (left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					left = $urandom_range(20, 80);
				end
				left--;
				phase++;
				case (mode)
					RX_FREE:   result_if.ready <= 1'b1;
					RX_COIN:   result_if.ready <= 1'($urandom);
					RX_SPARSE: result_if.ready <= (phase % 4 == 0);
					default:   result_if.ready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin : result_check
		out_word_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			words_seen++;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$error("sample_out: expected no word, got %0d", result_if.sample_out);
			end else begin
				want = expected_words.pop_front();
				if (result_if.sample_out !== want.sample) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$error("sample_out: expected %0d, got %0d", want.sample,
							result_if.sample_out);
				end
				if (result_if.run_last !== want.run_last) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$error("run_last: expected %0b, got %0b", want.run_last,
							result_if.run_last);
				end
				if (result_if.frame_end !== want.frame_end) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$error("frame_end: expected %0b, got %0b", want.frame_end,
							result_if.frame_end);
				end
			end
		end
	end

	initial begin : stimulus
		int                 sent;
		int                 flen;
		int                 walk;
		bit                 paused;
		logic signed [15:0] smp;
		arst_n             = 1'b0;
		feed_if.valid      = 1'b0;
		feed_if.sample_in  = '0;
		feed_if.frame_last = 1'b0;
		prior_in           = '0;
		first_frame        = 1'b1;
		frame_pos          = '0;
		emit_hist[0]       = '0;
		emit_hist[1]       = '0;
		for (int k = 0; k < LAG; k++)
			pend_raw[k] = '0;
		mismatches = 0;
		words_seen = 0;
		hold_stall = 1'b0;
		burst_left = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_sample(16'(directed_rows[i].smp), directed_rows[i].last,
				directed_rows[i].typed, directed_rows[i].count, directed_rows[i].val);

		sent   = 0;
		walk   = 0;
		paused = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			// mostly frames long enough to reach the smoothed body
			case ($urandom_range(0, 9))
				0, 1:    flen = $urandom_range(1, 2);
				2:       flen = $urandom_range(3, 4);
				default: flen = $urandom_range(5, 24);
			endcase
			if (flen > RANDOM_ITEMS - sent)
				flen = RANDOM_ITEMS - sent;
			for (int i = 0; i < flen; i++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: smp = 16'($urandom);
					5, 6: begin
						walk = walk + int'($urandom_range(0, 2000)) - 1000;
						if (walk > 32767)
							walk = 32767;
						if (walk < -32768)
							walk = -32768;
						smp = 16'(walk);
					end
					7, 8: begin
						case ($urandom_range(0, 4))
							0:       smp = 16'sh7fff;
							1:       smp = 16'sh8000;
							2:       smp = 16'sd0;
							3:       smp = -16'sd1;
							default: smp = 16'sd1;
						endcase
					end
					default: smp = 16'(int'($urandom_range(0, 16)) - 8);
				endcase
				walk = smp;
				send_sample(smp, i == flen - 1, 1'b0, 0, 0);
			end
			sent += flen;
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				paused = 1'b1;
				wait_idle();
			end
		end

		wait_idle();
		if (expected_words.size() != 0) begin
			mismatches++;
			$error("sample_out: expected %0d more words, got none", expected_words.size());
		end
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
